[src/bscc_pkg.sv]
package bscc_pkg;

   // Field and register widths of the block's ports.
   localparam int WORD_W       = 64;
   localparam int WORD_LOG     = 6;
   localparam int VAR_COUNT_W  = 5;
   localparam int BOUND_SIZE_W = 3;
   localparam int BIT_OFFSET_W = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int RSP_TDATA_W  = 8;
   localparam int COUNT_W      = 3;

   // A sub-word cofactor is at most 32 bits long; a whole-word cofactor is
   // kept as its 6-bit index, which fits the same field.
   localparam int SLICE_W = 32;

   // Running bit position of a sub-word slice: 16-bit offset plus up to
   // 63 slices of 32 bits.
   localparam int POS_W = 17;

   // Legal ranges after clamping.
   localparam logic [VAR_COUNT_W-1:0]  NV_MIN = 5'd4;
   localparam logic [BOUND_SIZE_W-1:0] NB_MIN = 3'd3;
   localparam logic [BOUND_SIZE_W-1:0] NB_MAX = 3'd6;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_VAR_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUND_SIZE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_OFFSET = 2'd2;

   // A cofactor travelling down the chain. An insert token skips the value
   // compare and lands in the first free cell.
   typedef struct packed {
      logic               valid;
      logic               insert;
      logic [SLICE_W-1:0] value;
   } token_type;

   typedef struct packed {
      logic busy;
      logic full;
   } chain_status_type;

endpackage

[src/bscc_table_ram.sv]
module bscc_table_ram #(
   parameter int AW = 10
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [bscc_pkg::WORD_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_a_addr,
   output logic [bscc_pkg::WORD_W-1:0] rd_a_data,
   input  logic [AW-1:0]              rd_b_addr,
   output logic [bscc_pkg::WORD_W-1:0] rd_b_data
);
   import bscc_pkg::*;

   logic [WORD_W-1:0] mem [2**AW];
   logic [WORD_W-1:0] rd_a_ff;
   logic [WORD_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

[src/bscc_cell.sv]
module bscc_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  bscc_pkg::token_type         tok_up,
   output bscc_pkg::token_type         tok_down,
   output logic                        occupied,
   output logic [bscc_pkg::SLICE_W-1:0] value
);
   import bscc_pkg::*;

   logic               occupied_ff;
   logic [SLICE_W-1:0] value_ff;
   logic               tok_valid_ff;
   logic               tok_insert_ff;
   logic [SLICE_W-1:0] tok_value_ff;
   logic               hit;
   logic               capture;

   // A token that matches the held cofactor is absorbed here; a token that
   // reaches a free cell becomes its cofactor.
   assign hit     = occupied_ff && !tok_up.insert && (tok_up.value == value_ff);
   assign capture = tok_up.valid && !occupied_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         occupied_ff  <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_up.valid && occupied_ff && !hit;
         if (capture) begin
            occupied_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      tok_insert_ff <= tok_up.insert;
      tok_value_ff  <= tok_up.value;
      if (capture) begin
         value_ff <= tok_up.value;
      end
   end

   assign tok_down = '{valid: tok_valid_ff, insert: tok_insert_ff, value: tok_value_ff};
   assign occupied = occupied_ff;
   assign value    = value_ff;

endmodule

[src/bscc_chain.sv]
module bscc_chain #(
   parameter int CELLS = 5
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    clear,
   input  bscc_pkg::token_type                     tok_in,
   output bscc_pkg::chain_status_type              status,
   output logic [$clog2(CELLS+1)-1:0]              count,
   output logic [CELLS-1:0][bscc_pkg::SLICE_W-1:0] cell_value
);
   import bscc_pkg::*;

   localparam int CNT_W = $clog2(CELLS+1);

   token_type          tok [CELLS+1];
   logic [CELLS-1:0]   occupied;

   assign tok[0] = tok_in;

   for (genvar c = 0; c < CELLS; c++) begin : g_cell
      bscc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .clear    (clear),
         .tok_up   (tok[c]),
         .tok_down (tok[c+1]),
         .occupied (occupied[c]),
         .value    (cell_value[c])
      );
   end

   always_comb begin
      status.busy = 1'b0;
      for (int c = 1; c <= CELLS; c++) begin
         status.busy = status.busy | tok[c].valid;
      end
      status.full = &occupied;
      count = '0;
      for (int c = 0; c < CELLS; c++) begin
         count = count + CNT_W'(occupied[c]);
      end
   end

endmodule

[src/bound_set_cofactor_counter.sv]
// Bound-set cofactor counter. The block takes a truth table of var_count
// inputs on the req_ channel as 64-bit items, lowest word first, one item per
// clock, and writes them into a table memory of 2^(MAX_VARS-6) words; words
// beyond its depth are dropped. The item that carries req_tlast starts the
// count: the 2^bound_size cofactors over the topmost bound_size variables are
// walked in order, and rsp_ later returns one item with the number of
// distinct cofactors, saturating at MAX_DISTINCT. The distinct cofactors are
// kept in a chain of MAX_DISTINCT cells; each new cofactor enters the first
// cell and moves one cell per clock until it either meets an equal cofactor
// or settles in the first free cell. When a cofactor is shorter than 64 bits
// it is cut from a single table word at bit_offset plus its index times its
// length, so the walk issues one table read per clock. When a cofactor
// spans whole words, bit_offset is ignored and each candidate is compared
// word by word against the held cofactors through the table's two read
// ports, and a new cofactor is pushed into the chain; this walk stops once
// the chain is full. req_tready is low from the last word until the count
// is finished. The result sits in an output register, so loading of the
// next table can begin while the previous count waits on rsp_tready. The
// user must write configuration on the csr_ port only while no table is
// being counted; the block itself has no check for this. The table memory
// needs no clearing after reset.
module bound_set_cofactor_counter #(
   parameter int MAX_VARS     = 16,
   parameter int MAX_DISTINCT = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bscc_pkg::WORD_W-1:0]       req_tdata,   // [63:0] table_word
   input  logic                              req_tlast,   // last_word
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bscc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // [2:0] cofactor_count, rest zero
   input  logic                              csr_we,
   input  logic [bscc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bscc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bscc_pkg::*;

   localparam int AW    = MAX_VARS - WORD_LOG;
   localparam int WW    = (MAX_VARS > 9) ? (MAX_VARS - 9) : 1;
   localparam int SEL_W = $clog2(MAX_DISTINCT);
   localparam int CNT_W = $clog2(MAX_DISTINCT + 1);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SUB_RUN,
      ST_SUB_DRAIN,
      ST_WORD_NEXT,
      ST_WORD_CMP,
      ST_WORD_WAIT,
      ST_WORD_PUSH,
      ST_FINISH
   } state_type;

   // Configuration registers.
   logic [VAR_COUNT_W-1:0]  var_count_ff;
   logic [BOUND_SIZE_W-1:0] bound_size_ff;
   logic [BIT_OFFSET_W-1:0] bit_offset_ff;

   // Control and walk registers.
   state_type          state_ff,      state_in;
   logic [AW:0]        load_index_ff, load_index_in;
   logic [5:0]         mint_last_ff,  mint_last_in;
   logic [5:0]         len_ff,        len_in;
   logic [2:0]         wlog_ff,       wlog_in;
   logic [6:0]         cand_ff,       cand_in;
   logic [POS_W-1:0]   pos_ff,        pos_in;
   logic [AW-1:0]      cand_base_ff,  cand_base_in;
   logic [SEL_W-1:0]   cell_sel_ff,   cell_sel_in;
   logic [WW-1:0]      word_ff,       word_in;
   logic               eq_ff,         eq_in;
   logic [5:0]         rd_sh_ff,      rd_sh_in;
   logic               rd_v_ff,       rd_v_in;
   logic               push_v_ff,     push_v_in;
   logic [SLICE_W-1:0] push_val_ff,   push_val_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff,  rsp_count_in;

   // Table memory.
   logic              ram_we;
   logic [AW-1:0]     ram_a_addr;
   logic [AW-1:0]     ram_b_addr;
   logic [WORD_W-1:0] rd_a_data;
   logic [WORD_W-1:0] rd_b_data;

   // Chain.
   logic                             chain_clear;
   token_type                        chain_tok;
   chain_status_type                 chain_status;
   logic [CNT_W-1:0]                 chain_count;
   logic [MAX_DISTINCT-1:0][SLICE_W-1:0] cell_value;

   // Derived values.
   logic                     req_accept;
   logic [VAR_COUNT_W-1:0]   nv_c;
   logic [BOUND_SIZE_W-1:0]  nb_c;
   logic [VAR_COUNT_W-1:0]   free_vars;
   logic [WORD_W-1:0]        slice_mask;
   logic [SLICE_W-1:0]       slice_value;
   logic [SLICE_W-1:0]       ref_value;
   logic [AW-1:0]            ref_base;
   logic [AW-1:0]            nw_step;
   logic [WW-1:0]            nw_last;
   logic                     words_match;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_LOAD);

   // Clamp the table size and the bound set to their legal ranges.
   always_comb begin
      if (var_count_ff < NV_MIN) begin
         nv_c = NV_MIN;
      end else if (var_count_ff > VAR_COUNT_W'(MAX_VARS)) begin
         nv_c = VAR_COUNT_W'(MAX_VARS);
      end else begin
         nv_c = var_count_ff;
      end
      if (bound_size_ff < NB_MIN) begin
         nb_c = NB_MIN;
      end else if (bound_size_ff > NB_MAX) begin
         nb_c = NB_MAX;
      end else begin
         nb_c = bound_size_ff;
      end
      if (VAR_COUNT_W'(nb_c) >= nv_c) begin
         nb_c = BOUND_SIZE_W'(nv_c - 5'd1);
      end
      free_vars = nv_c - VAR_COUNT_W'(nb_c);
   end

   // Sub-word cofactor cut from the word read in the previous cycle.
   assign slice_mask  = (64'd1 << len_ff) - 64'd1;
   assign slice_value = SLICE_W'((rd_a_data >> rd_sh_ff) & slice_mask);

   // Whole-word compare: the reference cofactor's first word is its index
   // times the number of words per cofactor.
   assign ref_value   = cell_value[cell_sel_ff];
   assign ref_base    = AW'(ref_value << wlog_ff);
   assign nw_step     = AW'(16'd1 << wlog_ff);
   assign nw_last     = WW'((16'd1 << wlog_ff) - 16'd1);
   assign words_match = (rd_a_data == rd_b_data);

   assign chain_tok = '{valid:  rd_v_ff || push_v_ff,
                        insert: push_v_ff,
                        value:  push_v_ff ? push_val_ff : slice_value};

   assign ram_we = req_accept && !load_index_ff[AW];

   always_comb begin
      state_in      = state_ff;
      load_index_in = load_index_ff;
      mint_last_in  = mint_last_ff;
      len_in        = len_ff;
      wlog_in       = wlog_ff;
      cand_in       = cand_ff;
      pos_in        = pos_ff;
      cand_base_in  = cand_base_ff;
      cell_sel_in   = cell_sel_ff;
      word_in       = word_ff;
      eq_in         = eq_ff;
      rd_sh_in      = rd_sh_ff;
      rd_v_in       = 1'b0;
      push_v_in     = 1'b0;
      push_val_in   = push_val_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_count_in  = rsp_count_ff;
      chain_clear   = 1'b0;
      ram_a_addr    = cand_base_ff + AW'(word_ff);
      ram_b_addr    = ref_base + AW'(word_ff);

      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (req_tlast) begin
                  load_index_in = '0;
                  chain_clear   = 1'b1;
                  mint_last_in  = 6'((7'd1 << nb_c) - 7'd1);
                  len_in        = 6'(6'd1 << free_vars);
                  wlog_in       = 3'(free_vars - 5'd6);
                  cand_in       = '0;
                  pos_in        = POS_W'(bit_offset_ff);
                  cand_base_in  = '0;
                  state_in      = (free_vars < 5'd6) ? ST_SUB_RUN : ST_WORD_NEXT;
               end else if (!load_index_ff[AW]) begin
                  load_index_in = load_index_ff + 1'b1;
               end
            end
         end
         ST_SUB_RUN: begin
            ram_a_addr = pos_ff[AW+5:6];
            rd_v_in    = 1'b1;
            rd_sh_in   = pos_ff[5:0];
            pos_in     = pos_ff + POS_W'(len_ff);
            cand_in    = cand_ff + 7'd1;
            if (cand_ff == {1'b0, mint_last_ff}) begin
               state_in = ST_SUB_DRAIN;
            end
         end
         ST_SUB_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_WORD_NEXT: begin
            if (cand_ff > {1'b0, mint_last_ff} || chain_status.full) begin
               state_in = ST_FINISH;
            end else if (chain_count == '0) begin
               push_v_in    = 1'b1;
               push_val_in  = SLICE_W'(cand_ff);
               cand_in      = cand_ff + 7'd1;
               cand_base_in = cand_base_ff + nw_step;
               state_in     = ST_WORD_PUSH;
            end else begin
               cell_sel_in = '0;
               word_in     = '0;
               eq_in       = 1'b1;
               state_in    = ST_WORD_CMP;
            end
         end
         ST_WORD_CMP: begin
            // Data of the previous word of this pair is back from memory.
            if (word_ff != '0) begin
               eq_in = eq_ff && words_match;
            end
            word_in = word_ff + 1'b1;
            if (word_ff == nw_last) begin
               state_in = ST_WORD_WAIT;
            end
         end
         ST_WORD_WAIT: begin
            if (eq_ff && words_match) begin
               cand_in      = cand_ff + 7'd1;
               cand_base_in = cand_base_ff + nw_step;
               state_in     = ST_WORD_NEXT;
            end else if (CNT_W'(cell_sel_ff) + CNT_W'(1) == chain_count) begin
               push_v_in    = 1'b1;
               push_val_in  = SLICE_W'(cand_ff);
               cand_in      = cand_ff + 7'd1;
               cand_base_in = cand_base_ff + nw_step;
               state_in     = ST_WORD_PUSH;
            end else begin
               cell_sel_in = cell_sel_ff + 1'b1;
               word_in     = '0;
               eq_in       = 1'b1;
               state_in    = ST_WORD_CMP;
            end
         end
         ST_WORD_PUSH: begin
            if (!push_v_ff && !chain_status.busy) begin
               state_in = ST_WORD_NEXT;
            end
         end
         ST_FINISH: begin
            if (!chain_status.busy && (!rsp_valid_ff || rsp_tready)) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = COUNT_W'(chain_count);
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         load_index_ff <= '0;
         rd_v_ff       <= 1'b0;
         push_v_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_index_ff <= load_index_in;
         rd_v_ff       <= rd_v_in;
         push_v_ff     <= push_v_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mint_last_ff <= mint_last_in;
      len_ff       <= len_in;
      wlog_ff      <= wlog_in;
      cand_ff      <= cand_in;
      pos_ff       <= pos_in;
      cand_base_ff <= cand_base_in;
      cell_sel_ff  <= cell_sel_in;
      word_ff      <= word_in;
      eq_ff        <= eq_in;
      rd_sh_ff     <= rd_sh_in;
      push_val_ff  <= push_val_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         var_count_ff  <= 5'd6;
         bound_size_ff <= 3'd3;
         bit_offset_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VAR_COUNT:  var_count_ff  <= csr_wdata[VAR_COUNT_W-1:0];
            CSR_BOUND_SIZE: bound_size_ff <= csr_wdata[BOUND_SIZE_W-1:0];
            CSR_BIT_OFFSET: bit_offset_ff <= csr_wdata[BIT_OFFSET_W-1:0];
            default: begin
            end
         endcase
      end
   end

   bscc_table_ram #(
      .AW (AW)
   ) u_table_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (load_index_ff[AW-1:0]),
      .wr_data   (req_tdata),
      .rd_a_addr (ram_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_addr (ram_b_addr),
      .rd_b_data (rd_b_data)
   );

   bscc_chain #(
      .CELLS (MAX_DISTINCT)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .clear      (chain_clear),
      .tok_in     (chain_tok),
      .status     (chain_status),
      .count      (chain_count),
      .cell_value (cell_value)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_count_ff);

endmodule

[src/bscc_checker.sv]
module bscc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             req_tlast,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [bscc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import bscc_pkg::*;

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or vanished while stalled");

   // Only the count bits of the result are ever set.
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_TDATA_W-1:COUNT_W] == '0))
      else $error("result padding bits set");

   // The last word of a table stops intake while the count runs.
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input still ready after the last word");

   // A new result only comes out of the counting phase.
   a_rsp_after_count: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result raised while loading");

endmodule

bind bound_set_cofactor_counter bscc_checker u_bscc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
